/* hdl/s1sh_pkg.sv */
// ----------------------------------------------------------------------------
// s1sh_pkg
// Types and constants shared by the SHA-1 stream hasher and its round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s1sh_pkg;

  typedef enum logic [1:0] {
    ACT_ABSORB        = 2'd0,
    ACT_ABSORB_FINISH = 2'd1,
    ACT_FINISH        = 2'd2,
    ACT_NONE          = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // working variables of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  localparam int unsigned NUM_WORDS = 5;

  localparam logic [NUM_WORDS-1:0][31:0] INIT_WORDS = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [6:0] RND_SCHED = 7'd16;
  localparam logic [6:0] RND_PH1   = 7'd20;
  localparam logic [6:0] RND_PH2   = 7'd40;
  localparam logic [6:0] RND_PH3   = 7'd60;
  localparam logic [6:0] RND_LAST  = 7'd79;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [2:0] LAST_IDX  = 3'd4;

endpackage

/* hdl/s1sh_round.sv */
// ----------------------------------------------------------------------------
// s1sh_round
// One SHA-1 round: selects f and k by round number and rotates the working
// variables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s1sh_round (
  input  s1sh_pkg::work_t work_i,
  input  logic [31:0]     w_i,
  input  logic [6:0]      rnd_i,
  output s1sh_pkg::work_t work_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] a_rot;
  logic [31:0] t;

  always_comb begin
    if (rnd_i < s1sh_pkg::RND_PH1) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = s1sh_pkg::K_0;
    end else if (rnd_i < s1sh_pkg::RND_PH2) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = s1sh_pkg::K_1;
    end else if (rnd_i < s1sh_pkg::RND_PH3) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = s1sh_pkg::K_2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = s1sh_pkg::K_3;
    end
  end

  assign a_rot = {work_i.a[26:0], work_i.a[31:27]};
  assign t     = a_rot + f + work_i.e + k + w_i;

  assign work_o.a = t;
  assign work_o.b = work_i.a;
  assign work_o.c = {work_i.b[1:0], work_i.b[31:2]};
  assign work_o.d = work_i.c;
  assign work_o.e = work_i.d;

endmodule

/* hdl/sha1_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream; emits the digest as five 32-bit words on finish.
// ----------------------------------------------------------------------------
// Blocks: the 64th byte of a block starts a compression of 80 rounds through one
//   shared round unit, then one fold into the chain.
// Finish: one padding byte per cycle up to the block end, then one or two
//   compressions, then five output beats.
// Input: no byte is accepted while a block is compressed, padded or read out.
// Reset: asynchronous, active low; loads the initial hash and clears counts.
`timescale 1ns / 1ps

module sha1_stream_hasher (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  s1sh_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output s1sh_pkg::out_t  out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e                                    state_q;
  logic [s1sh_pkg::NUM_WORDS-1:0][31:0]      chain_q;
  logic [511:0]                              msg_q;
  logic [5:0]                                fill_q;
  logic [60:0]                               total_q;
  logic [6:0]                                rnd_q;
  s1sh_pkg::work_t                           work_q;
  s1sh_pkg::work_t                           work_d;
  logic                                      fin_q;
  logic                                      marked_q;
  logic                                      len_en_q;
  logic                                      last_q;
  logic                                      out_valid_q;
  s1sh_pkg::out_t                            out_q;

  logic [31:0]                               w_new;
  logic [31:0]                               w_mix;
  logic [63:0]                               len_shift;
  logic [7:0]                                pad_byte;
  logic [s1sh_pkg::NUM_WORDS-1:0][31:0]      sum;
  s1sh_pkg::work_t                           work_init;
  logic [2:0]                                idx_next;
  logic                                      in_fire;
  logic                                      out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;

  // schedule taps: words 0, 2, 8 and 13 of the rolling window
  assign w_mix = msg_q[511:480] ^ msg_q[447:416] ^ msg_q[255:224] ^ msg_q[95:64];
  assign w_new = (rnd_q < s1sh_pkg::RND_SCHED) ? msg_q[511:480]
                                               : {w_mix[30:0], w_mix[31]};

  s1sh_round u_round (
    .work_i (work_q),
    .w_i    (w_new),
    .rnd_i  (rnd_q),
    .work_o (work_d)
  );

  assign len_shift = {total_q, 3'b000} << {fill_q[2:0], 3'b000};

  always_comb begin
    if (!marked_q) begin
      pad_byte = s1sh_pkg::PAD_MARK;
    end else if (len_en_q && (fill_q >= s1sh_pkg::LEN_POS)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign work_init.a = chain_q[0];
  assign work_init.b = chain_q[1];
  assign work_init.c = chain_q[2];
  assign work_init.d = chain_q[3];
  assign work_init.e = chain_q[4];

  assign sum[0] = chain_q[0] + work_q.a;
  assign sum[1] = chain_q[1] + work_q.b;
  assign sum[2] = chain_q[2] + work_q.c;
  assign sum[3] = chain_q[3] + work_q.d;
  assign sum[4] = chain_q[4] + work_q.e;

  assign idx_next = out_q.word_index + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= s1sh_pkg::INIT_WORDS;
      fill_q      <= '0;
      total_q     <= '0;
      rnd_q       <= '0;
      fin_q       <= 1'b0;
      marked_q    <= 1'b0;
      len_en_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data_i.action)
              s1sh_pkg::ACT_ABSORB,
              s1sh_pkg::ACT_ABSORB_FINISH: begin
                msg_q   <= {msg_q[503:0], in_data_i.data_byte};
                fill_q  <= fill_q + 6'd1;
                total_q <= total_q + 61'd1;
                fin_q   <= (in_data_i.action == s1sh_pkg::ACT_ABSORB_FINISH);
                if (&fill_q) begin
                  work_q  <= work_init;
                  rnd_q   <= '0;
                  state_q <= ST_ROUND;
                end else if (in_data_i.action == s1sh_pkg::ACT_ABSORB_FINISH) begin
                  state_q <= ST_PAD;
                end
              end
              s1sh_pkg::ACT_FINISH: begin
                fin_q   <= 1'b1;
                state_q <= ST_PAD;
              end
              default: begin
              end
            endcase
          end
        end

        ST_PAD: begin
          msg_q  <= {msg_q[503:0], pad_byte};
          fill_q <= fill_q + 6'd1;
          if (!marked_q) begin
            marked_q <= 1'b1;
            if (fill_q < s1sh_pkg::LEN_POS) begin
              len_en_q <= 1'b1;
            end
          end
          if (&fill_q) begin
            last_q  <= len_en_q;
            work_q  <= work_init;
            rnd_q   <= '0;
            state_q <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          work_q <= work_d;
          msg_q  <= {msg_q[479:0], w_new};
          rnd_q  <= rnd_q + 7'd1;
          if (rnd_q == s1sh_pkg::RND_LAST) begin
            state_q <= ST_FOLD;
          end
        end

        ST_FOLD: begin
          chain_q <= sum;
          if (last_q) begin
            out_valid_q       <= 1'b1;
            out_q.digest_word <= sum[0];
            out_q.word_index  <= '0;
            out_q.last_word   <= 1'b0;
            state_q           <= ST_OUT;
          end else if (fin_q) begin
            len_en_q <= len_en_q | marked_q;
            state_q  <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end

        ST_OUT: begin
          if (out_fire) begin
            if (out_q.last_word) begin
              out_valid_q <= 1'b0;
              chain_q     <= s1sh_pkg::INIT_WORDS;
              fill_q      <= '0;
              total_q     <= '0;
              fin_q       <= 1'b0;
              marked_q    <= 1'b0;
              len_en_q    <= 1'b0;
              last_q      <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              out_q.digest_word <= chain_q[idx_next];
              out_q.word_index  <= idx_next;
              out_q.last_word   <= (idx_next == s1sh_pkg::LAST_IDX);
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/sv/sha1_stream_hasher_tb.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Self-checking bench for the SHA-1 stream hasher. A built-in SHA-1 digest
// model follows every accepted input beat and queues the five digest words
// that each finish must produce. Directed messages come first: the empty
// message, single bytes, ignored actions and a long output hold-off. Then
// random messages run, sized around the padding and block boundaries, with
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_stream_hasher_tb;

  localparam int unsigned RANDOM_ITEMS = 260;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  s1sh_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  s1sh_pkg::out_t out_data_o;

  // digest model state
  logic [31:0] hash_words [s1sh_pkg::NUM_WORDS];
  logic [7:0]  blk_bytes  [64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_bytes;

  s1sh_pkg::out_t digest_q [$];
  s1sh_pkg::out_t exp_beat;

  int unsigned errors        = 0;
  int unsigned words_checked = 0;
  int unsigned items_sent    = 0;
  int unsigned messages_sent = 0;
  int unsigned cycle_count   = 0;
  bit          no_idle       = 1'b0;
  bit          hold_req      = 1'b0;

  sha1_stream_hasher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic init_hash();
    for (int i = 0; i < s1sh_pkg::NUM_WORDS; i++) hash_words[i] = s1sh_pkg::INIT_WORDS[i];
    blk_fill  = '0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, t, w;
    for (int unsigned r = 0; r < 16; r++) begin
      sched[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int unsigned r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = rotl(sched[(r-3) & 15] ^ sched[(r-8) & 15] ^
                 sched[(r-14) & 15] ^ sched[r & 15], 1);
        sched[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = s1sh_pkg::K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = s1sh_pkg::K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = s1sh_pkg::K_2;
      end else begin
        f = b ^ c ^ d;
        k = s1sh_pkg::K_3;
      end
      t = rotl(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk_bytes[blk_fill] = v;
    blk_fill  = blk_fill + 6'd1;
    msg_bytes = msg_bytes + 61'd1;
    if (blk_fill == '0) compress_block();
  endtask

  task automatic finish_digest();
    logic [63:0]    bit_len;
    int unsigned    pos;
    s1sh_pkg::out_t beat;
    bit_len = {msg_bytes, 3'b000};
    pos = blk_fill;
    blk_bytes[pos] = s1sh_pkg::PAD_MARK;
    pos++;
    if (pos > s1sh_pkg::LEN_POS) begin
      while (pos < 64) begin
        blk_bytes[pos] = '0;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < s1sh_pkg::LEN_POS) begin
      blk_bytes[pos] = '0;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[s1sh_pkg::LEN_POS + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < s1sh_pkg::NUM_WORDS; i++) begin
      beat.digest_word = hash_words[i];
      beat.word_index  = 3'(i);
      beat.last_word   = (3'(i) == s1sh_pkg::LAST_IDX);
      digest_q = {digest_q, beat};
    end
    init_hash();
  endtask

  task automatic model_beat(input s1sh_pkg::in_t beat);
    case (beat.action)
      s1sh_pkg::ACT_ABSORB:        absorb_byte(beat.data_byte);
      s1sh_pkg::ACT_ABSORB_FINISH: begin
        absorb_byte(beat.data_byte);
        finish_digest();
      end
      s1sh_pkg::ACT_FINISH:        finish_digest();
      default:                     ;
    endcase
  endtask

  // output check first, then model update for the input beat of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat, expected none, actual word %h index %0d last %0b",
                   $realtime, out_data_o.digest_word, out_data_o.word_index,
                   out_data_o.last_word);
          errors++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (out_data_o !== exp_beat) begin
            $display("%0t: digest mismatch, expected word %h index %0d last %0b,",
                     $realtime, exp_beat.digest_word, exp_beat.word_index,
                     exp_beat.last_word);
            $display("%0t:   actual word %h index %0d last %0b",
                     $realtime, out_data_o.digest_word, out_data_o.word_index,
                     out_data_o.last_word);
            errors++;
          end
          words_checked++;
        end
      end
      if (in_valid_i && in_ready_o) model_beat(in_data_i);
    end
  end

  // receiver: random idle per beat, one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_beat(input s1sh_pkg::action_e act, input logic [7:0] v);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.action    <= act;
    in_data_i.data_byte <= v;
    do @(posedge clk_i); while (!in_ready_o);
    if (act != s1sh_pkg::ACT_NONE) items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_with_byte, input bit noise);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 15) == 0) begin
        send_beat(s1sh_pkg::ACT_NONE, 8'($urandom_range(0, 255)));
      end
      if (end_with_byte && i == len - 1) begin
        send_beat(s1sh_pkg::ACT_ABSORB_FINISH, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(s1sh_pkg::ACT_ABSORB, 8'($urandom_range(0, 255)));
      end
    end
    if (!(end_with_byte && len > 0)) begin
      send_beat(s1sh_pkg::ACT_FINISH, 8'($urandom_range(0, 255)));
    end
    messages_sent++;
  endtask

  task automatic test_empty_message();
    send_beat(s1sh_pkg::ACT_FINISH, 8'h00);
    send_beat(s1sh_pkg::ACT_FINISH, 8'hFF);
    messages_sent += 2;
  endtask

  task automatic test_single_byte();
    send_beat(s1sh_pkg::ACT_ABSORB_FINISH, 8'h00);
    send_beat(s1sh_pkg::ACT_ABSORB_FINISH, 8'hFF);
    messages_sent += 2;
  endtask

  task automatic test_ignored_action();
    send_beat(s1sh_pkg::ACT_NONE, 8'hFF);
    send_beat(s1sh_pkg::ACT_ABSORB, 8'h61);
    send_beat(s1sh_pkg::ACT_NONE, 8'h00);
    send_beat(s1sh_pkg::ACT_ABSORB, 8'h62);
    send_beat(s1sh_pkg::ACT_ABSORB, 8'h63);
    send_beat(s1sh_pkg::ACT_NONE, 8'hA5);
    send_beat(s1sh_pkg::ACT_FINISH, 8'hFF);
    messages_sent++;
  endtask

  task automatic test_output_hold();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++) send_message(8, i[0], 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_messages();
    int unsigned target;
    int unsigned len;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       len = 55;
          1:       len = 63;
          2:       len = 119;
          default: len = 127;
        endcase
        len += $urandom_range(0, 2);
      end else begin
        len = $urandom_range(0, 12);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      send_message(len, $urandom_range(0, 1), 1'b1);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    init_hash();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_single_byte();
    test_ignored_action();
    test_output_hold();
    test_random_messages();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Hashed %0d messages from %0d input beats, incl. empty, 1-byte and boundary sizes",
             messages_sent, items_sent);
    $display("Checked %0d digest words, with one long output hold-off, %0d errors",
             words_checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
